// ===== hdl/dds_sample_player_assert.svh =====
`ifndef DDS_SAMPLE_PLAYER_ASSERT_SVH
`define DDS_SAMPLE_PLAYER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define DSP_ASSERT_IMP(lbl, ck, rst_n, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("dsp assertion failed");

// next-cycle implication, checked outside reset
`define DSP_ASSERT_NXT(lbl, ck, rst_n, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("dsp assertion failed");

`endif

// ===== hdl/dsp_pkg.sv =====
package dsp_pkg;

	localparam int unsigned DEPTH_DEFAULT = 4096;

	localparam int OP_W     = 2;
	localparam int ENTRY_W  = 12;
	localparam int WORD_W   = 32;
	localparam int BYTE_W   = 8;
	localparam int LEN_W    = 13;
	localparam int PADDR_W  = 4;
	localparam int PDATA_W  = 32;
	localparam int CNT_W    = 3;

	localparam logic [CNT_W-1:0] LAST_BYTE = 3'd4;

	typedef enum logic [OP_W-1:0] {
		OP_WRITE  = 2'd0,
		OP_TICK   = 2'd1,
		OP_DIRECT = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		REG_BUF_LEN = 2'd0,
		REG_STEP    = 2'd1,
		REG_MODE    = 2'd2,
		REG_CTRL    = 2'd3
	} reg_idx_t;

	localparam logic [LEN_W-1:0]  BUF_LEN_RST = 13'd0;
	localparam logic [LEN_W-1:0]  STEP_RST    = 13'd1;
	localparam logic [BYTE_W-1:0] CTRL_RST    = 8'd1;

	typedef struct packed {
		logic [LEN_W-1:0]  buffer_length;
		logic [LEN_W-1:0]  step_size;
		logic              stream_mode;
		logic [BYTE_W-1:0] control_byte;
	} cfg_t;

endpackage

// ===== hdl/dsp_if.sv =====
interface dsp_item_if;
	logic                         valid;
	logic                         ready;
	logic [dsp_pkg::OP_W-1:0]     op;
	logic [dsp_pkg::ENTRY_W-1:0]  entry_index;
	logic [dsp_pkg::WORD_W-1:0]   word_value;

	modport source (output valid, op, entry_index, word_value, input ready);
	modport sink (input valid, op, entry_index, word_value, output ready);
endinterface

interface dsp_frame_if;
	logic                         valid;
	logic                         ready;
	logic [dsp_pkg::BYTE_W-1:0]   frame_byte;
	logic                         last_byte;
	logic                         refill_notice;
	logic                         free_half;

	modport source (output valid, frame_byte, last_byte, refill_notice, free_half,
		input ready);
	modport sink (input valid, frame_byte, last_byte, refill_notice, free_half,
		output ready);
endinterface

// ===== hdl/dsp_ram.sv =====
module dsp_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== hdl/dsp_regs.sv =====
module dsp_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [dsp_pkg::PADDR_W-1:0]  paddr,
	input  logic [dsp_pkg::PDATA_W-1:0]  pwdata,
	output logic [dsp_pkg::PDATA_W-1:0]  prdata,
	output logic                         pready,
	output dsp_pkg::cfg_t                cfg
);

	import dsp_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t sel;
	logic     wr_en;

	assign sel    = reg_idx_t'(paddr[PADDR_W-1:2]);
	assign wr_en  = psel && penable && pwrite && pready;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.buffer_length <= BUF_LEN_RST;
			cfg_q.step_size     <= STEP_RST;
			cfg_q.stream_mode   <= 1'b0;
			cfg_q.control_byte  <= CTRL_RST;
		end else if (wr_en) begin
			unique case (sel)
				REG_BUF_LEN: cfg_q.buffer_length <= pwdata[LEN_W-1:0];
				REG_STEP:    cfg_q.step_size     <= pwdata[LEN_W-1:0];
				REG_MODE:    cfg_q.stream_mode   <= pwdata[0];
				REG_CTRL:    cfg_q.control_byte  <= pwdata[BYTE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (sel)
			REG_BUF_LEN: prdata = PDATA_W'(cfg_q.buffer_length);
			REG_STEP:    prdata = PDATA_W'(cfg_q.step_size);
			REG_MODE:    prdata = PDATA_W'(cfg_q.stream_mode);
			REG_CTRL:    prdata = PDATA_W'(cfg_q.control_byte);
			default:     prdata = '0;
		endcase
	end

endmodule

// ===== hdl/dds_sample_player.sv =====
// Sample player that feeds a synthesizer a five-byte frame (control byte, then the 32-bit
// frequency word most-significant byte first). An item is taken every cycle while the
// frame register can accept its result: a sample write emits nothing; a direct word, or a
// tick with a nonzero buffer length, emits five bytes via the input and frame registers,
// one per cycle while frame.ready is high. The single frame register shifts the bytes out
// and loads the next frame as the last byte is accepted. The sample memory is not cleared
// after reset; a tick that reads an entry never written returns an arbitrary word.
`include "dds_sample_player_assert.svh"

module dds_sample_player #(
	parameter int unsigned DEPTH = dsp_pkg::DEPTH_DEFAULT
) (
	input  logic                         clk,
	input  logic                         arst_n,
	dsp_item_if.sink                     item,
	dsp_frame_if.source                  frame,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [dsp_pkg::PADDR_W-1:0]  paddr,
	input  logic [dsp_pkg::PDATA_W-1:0]  pwdata,
	output logic [dsp_pkg::PDATA_W-1:0]  prdata,
	output logic                         pready
);

	import dsp_pkg::*;

	localparam int AW  = $clog2(DEPTH);
	localparam int LW  = $clog2(DEPTH + 1);
	localparam int CW  = ((LW > LEN_W) ? LW : LEN_W) + 1;
	localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

	cfg_t cfg;

	dsp_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// input register
	logic                s1_valid_q;
	logic [OP_W-1:0]     op_s1;
	logic [ENTRY_W-1:0]  idx_s1;
	logic [WORD_W-1:0]   word_s1;
	logic                in_xfer;
	logic                s1_fire;

	// frame register
	logic                s2_valid_q;
	logic [CNT_W-1:0]    cnt_q;
	logic                tick_s2;
	logic [WORD_W-1:0]   word_s2;
	logic [BYTE_W-1:0]   ctrl_s2;
	logic                notice_s2;
	logic                half_s2;
	logic                s2_free;
	logic                load_s2;

	// player state
	logic [AW-1:0]       rp_q;
	logic                half_q;

	logic                is_write;
	logic                is_tick;
	logic                is_direct;
	logic                emits;
	logic                tick_fire;
	logic [AW-1:0]       waddr;
	logic [WORD_W-1:0]   ram_rdata;
	logic [WORD_W-1:0]   out_word;

	logic [CW-1:0]       bl_ext;
	logic [CW-1:0]       len_c;
	logic [CW-1:0]       rp0;
	logic [CW-1:0]       st;
	logic [CW-1:0]       sum;
	logic [CW-1:0]       inc;
	logic [CW-1:0]       rp_next;
	logic                half_next;
	logic                notice_next;

	assign in_xfer    = item.valid && item.ready;
	assign item.ready = !s1_valid_q || s1_fire;

	always_comb begin
		is_write  = 1'b0;
		is_tick   = 1'b0;
		is_direct = 1'b0;
		unique case (op_s1)
			OP_WRITE:  is_write  = 1'b1;
			OP_TICK:   is_tick   = 1'b1;
			OP_DIRECT: is_direct = 1'b1;
			default: ;
		endcase
	end

	assign emits     = is_direct || (is_tick && len_c != '0);
	assign s2_free   = !s2_valid_q || (frame.ready && cnt_q == LAST_BYTE);
	assign s1_fire   = s1_valid_q && (!emits || s2_free);
	assign load_s2   = s1_fire && emits;
	assign tick_fire = s1_fire && is_tick && len_c != '0;

	// write address: entry index modulo the memory depth
	generate
		if (DEPTH < (1 << ENTRY_W)) begin : g_mod
			localparam int MOD_SH = 26;
			localparam int PW     = ENTRY_W + MOD_SH;
			localparam longint unsigned MOD_M = ((64'd1 << MOD_SH) / DEPTH) + 1;
			logic [PW-1:0]      prod;
			logic [ENTRY_W-1:0] q_s1;
			logic [ENTRY_W-1:0] rem;

			assign prod = PW'(item.entry_index) * PW'(MOD_M);

			always_ff @(posedge clk) begin
				if (in_xfer) begin
					q_s1 <= prod[PW-1:MOD_SH];
				end
			end

			assign rem   = idx_s1 - ENTRY_W'(q_s1 * ENTRY_W'(DEPTH));
			assign waddr = AW'(rem);
		end else begin : g_direct
			assign waddr = AW'(idx_s1);
		end
	endgenerate

	// pointer step
	always_comb begin
		bl_ext      = CW'(cfg.buffer_length);
		len_c       = (bl_ext > DEPTH_C) ? DEPTH_C : bl_ext;
		rp0         = (CW'(rp_q) >= len_c) ? '0 : CW'(rp_q);
		st          = (CW'(cfg.step_size) > len_c) ? CW'(1) : CW'(cfg.step_size);
		sum         = rp0 + st;
		inc         = rp0 + CW'(1);
		half_next   = half_q;
		notice_next = 1'b0;
		if (!cfg.stream_mode) begin
			rp_next = (sum >= len_c) ? sum - len_c : sum;
		end else if (inc >= len_c) begin
			rp_next     = '0;
			half_next   = 1'b1;
			notice_next = 1'b1;
		end else if (inc == (len_c >> 1)) begin
			rp_next     = inc;
			half_next   = 1'b0;
			notice_next = 1'b1;
		end else begin
			rp_next = inc;
		end
	end

	dsp_ram #(
		.WIDTH (WORD_W),
		.DEPTH (DEPTH)
	) u_mem (
		.clk   (clk),
		.we    (s1_valid_q && is_write),
		.waddr (waddr),
		.wdata (word_s1),
		.re    (tick_fire),
		.raddr (AW'(rp0)),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			s2_valid_q <= 1'b0;
			cnt_q      <= '0;
			rp_q       <= '0;
			half_q     <= 1'b0;
		end else begin
			if (in_xfer) begin
				s1_valid_q <= 1'b1;
			end else if (s1_fire) begin
				s1_valid_q <= 1'b0;
			end
			if (tick_fire) begin
				rp_q   <= AW'(rp_next);
				half_q <= half_next;
			end
			if (load_s2) begin
				s2_valid_q <= 1'b1;
				cnt_q      <= '0;
			end else if (s2_valid_q && frame.ready) begin
				if (cnt_q == LAST_BYTE) begin
					s2_valid_q <= 1'b0;
				end else begin
					cnt_q <= cnt_q + CNT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			op_s1   <= item.op;
			idx_s1  <= item.entry_index;
			word_s1 <= item.word_value;
		end
		if (load_s2) begin
			tick_s2   <= is_tick;
			word_s2   <= word_s1;
			ctrl_s2   <= cfg.control_byte;
			notice_s2 <= is_tick && notice_next;
			half_s2   <= is_tick ? half_next : half_q;
		end
	end

	assign out_word = tick_s2 ? ram_rdata : word_s2;

	always_comb begin
		case (cnt_q)
			3'd0:    frame.frame_byte = ctrl_s2;
			3'd1:    frame.frame_byte = out_word[31:24];
			3'd2:    frame.frame_byte = out_word[23:16];
			3'd3:    frame.frame_byte = out_word[15:8];
			default: frame.frame_byte = out_word[7:0];
		endcase
	end

	assign frame.valid         = s2_valid_q;
	assign frame.last_byte     = cnt_q == LAST_BYTE;
	assign frame.refill_notice = notice_s2 && cnt_q == LAST_BYTE;
	assign frame.free_half     = half_s2;

	`DSP_ASSERT_NXT(a_frame_ends, clk, arst_n, frame.valid && frame.ready && frame.last_byte && !load_s2, !frame.valid)
	`DSP_ASSERT_IMP(a_notice_stream, clk, arst_n, frame.valid && frame.refill_notice, frame.last_byte && cfg.stream_mode)
	`DSP_ASSERT_NXT(a_ptr_in_range, clk, arst_n, tick_fire, CW'(rp_q) < $past(len_c))
	`DSP_ASSERT_NXT(a_s1_hold, clk, arst_n, s1_valid_q && !s1_fire, s1_valid_q && $stable(op_s1))

endmodule
